FILE: hdl/ymsc_pkg.sv
package ymsc_pkg;

  // Protocol control characters
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  // Register defaults and indexes
  localparam logic [31:0] TOTAL_BYTES_RESET = 32'd0;
  localparam logic [15:0] TIMEOUT_MS_RESET  = 16'd1000;
  localparam logic [3:0]  MAX_RETRIES_RESET = 4'd10;

  typedef enum logic [1:0] {
    REG_TOTAL_BYTES = 2'd0,
    REG_TIMEOUT_MS  = 2'd1,
    REG_MAX_RETRIES = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_WAIT_C     = 3'd0,
    PH_HEADER_ACK = 3'd1,
    PH_DATA_C     = 3'd2,
    PH_DATA_ACK   = 3'd3,
    PH_EOT_NAK    = 3'd4,
    PH_EOT_ACK    = 3'd5,
    PH_FINAL_C    = 3'd6,
    PH_FINAL_ACK  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CAUSE_NONE       = 2'd0,
    CAUSE_RX_CANCEL  = 2'd1,
    CAUSE_TIMEOUT    = 2'd2,
    CAUSE_LOCAL_CANCEL = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_HDR    = 3'd1,
    ACT_EMPTY  = 3'd2,
    ACT_DATA   = 3'd3,
    ACT_EOT    = 3'd4,
    ACT_RESEND = 3'd5,
    ACT_CAN2   = 3'd6
  } action_e;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic [15:0] timeout_ms;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  rx_byte;
    logic [15:0] delta_ms;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    status_e     run_status;
    cause_e      fail_cause;
    logic [1:0]  cancel_count;
    logic [4:0]  retry_count;
    logic [16:0] wait_time;
    logic [31:0] file_offset;
    logic [7:0]  block_counter;
    logic [10:0] block_length;
  } state_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  block_number;
    logic [31:0] read_offset;
    logic [10:0] read_length;
    logic        progress_valid;
    logic [31:0] progress_offset;
    status_e     status;
    cause_e      error_cause;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_WAIT_C,
    run_status:    ST_RUN,
    fail_cause:    CAUSE_NONE,
    cancel_count:  2'd0,
    retry_count:   5'd0,
    wait_time:     17'd0,
    file_offset:   32'd0,
    block_counter: 8'd1,
    block_length:  11'd0
  };

endpackage

FILE: hdl/ymsc_cfg_regs.sv
module ymsc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output ymsc_pkg::cfg_t      cfg_o
);

  ymsc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index and replace the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ymsc_pkg::reg_idx_e'(cfg_idx_i))
        ymsc_pkg::REG_TOTAL_BYTES: cfg_d.total_bytes = cfg_data_i;
        ymsc_pkg::REG_TIMEOUT_MS:  cfg_d.timeout_ms  = cfg_data_i[15:0];
        ymsc_pkg::REG_MAX_RETRIES: cfg_d.max_retries = cfg_data_i[3:0];
        ymsc_pkg::REG_UNUSED:      cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_bytes <= ymsc_pkg::TOTAL_BYTES_RESET;
      cfg_q.timeout_ms  <= ymsc_pkg::TIMEOUT_MS_RESET;
      cfg_q.max_retries <= ymsc_pkg::MAX_RETRIES_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/ymsc_step.sv
module ymsc_step #(
  parameter int unsigned DATA_BLOCK_BYTES = 1024
) (
  input  ymsc_pkg::state_t  state_i,
  input  ymsc_pkg::cfg_t    cfg_i,
  input  ymsc_pkg::item_t   item_i,
  output ymsc_pkg::state_t  state_o,
  output ymsc_pkg::result_t result_o
);

  localparam logic [31:0] BlockMax = 32'(DATA_BLOCK_BYTES);

  always_comb begin
    ymsc_pkg::state_t  ns;
    ymsc_pkg::result_t res;
    logic [16:0] tick_sum;
    logic [31:0] acked;
    logic [31:0] blk_offset;
    logic [31:0] remain;
    logic [31:0] blk_len;
    logic [4:0]  retry_inc;
    logic [1:0]  can_inc;
    logic        send_blk;

    ns         = state_i;
    res        = '0;
    send_blk   = 1'b0;
    acked      = state_i.file_offset + 32'(state_i.block_length);
    blk_offset = state_i.file_offset;
    tick_sum   = state_i.wait_time + 17'(item_i.delta_ms);
    retry_inc  = (state_i.retry_count < 5'd31) ? state_i.retry_count + 5'd1
                                               : state_i.retry_count;
    can_inc    = (state_i.cancel_count < 2'd3) ? state_i.cancel_count + 2'd1
                                               : state_i.cancel_count;

    // Dispatch the event
    priority if (item_i.command == ymsc_pkg::CMD_RESTART) begin
      ns = ymsc_pkg::STATE_RESET;
    end else if (state_i.run_status == ymsc_pkg::ST_RUN) begin
      unique case (item_i.command)
        ymsc_pkg::CMD_BYTE: begin
          if (item_i.rx_byte == ymsc_pkg::CH_CAN) begin
            // Count CANs; the wait time keeps running
            ns.cancel_count = can_inc;
            if (can_inc >= 2'd2) begin
              ns.run_status = ymsc_pkg::ST_ERR;
              ns.fail_cause = ymsc_pkg::CAUSE_RX_CANCEL;
            end
          end else begin
            ns.cancel_count = 2'd0;
            unique case (state_i.phase)
              ymsc_pkg::PH_WAIT_C: begin
                if (item_i.rx_byte == ymsc_pkg::CH_C) begin
                  res.action     = ymsc_pkg::ACT_HDR;
                  ns.phase       = ymsc_pkg::PH_HEADER_ACK;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end
              end
              ymsc_pkg::PH_HEADER_ACK: begin
                if (item_i.rx_byte == ymsc_pkg::CH_ACK) begin
                  ns.phase       = ymsc_pkg::PH_DATA_C;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end else if (item_i.rx_byte == ymsc_pkg::CH_NAK) begin
                  res.action   = ymsc_pkg::ACT_RESEND;
                  ns.wait_time = 17'd0;
                end
              end
              ymsc_pkg::PH_DATA_C: begin
                if (item_i.rx_byte == ymsc_pkg::CH_C) begin
                  if (cfg_i.total_bytes == 32'd0) begin
                    res.action     = ymsc_pkg::ACT_EOT;
                    ns.phase       = ymsc_pkg::PH_EOT_NAK;
                    ns.retry_count = 5'd0;
                    ns.wait_time   = 17'd0;
                  end else begin
                    send_blk = 1'b1;
                  end
                end
              end
              ymsc_pkg::PH_DATA_ACK: begin
                if (item_i.rx_byte == ymsc_pkg::CH_ACK) begin
                  // Commit the acknowledged block, then EOT or next block
                  ns.file_offset     = acked;
                  res.progress_valid = 1'b1;
                  if (acked >= cfg_i.total_bytes) begin
                    res.action     = ymsc_pkg::ACT_EOT;
                    ns.phase       = ymsc_pkg::PH_EOT_NAK;
                    ns.retry_count = 5'd0;
                    ns.wait_time   = 17'd0;
                  end else begin
                    ns.block_counter = state_i.block_counter + 8'd1;
                    blk_offset       = acked;
                    send_blk         = 1'b1;
                  end
                end else if (item_i.rx_byte == ymsc_pkg::CH_NAK) begin
                  res.action   = ymsc_pkg::ACT_RESEND;
                  ns.wait_time = 17'd0;
                end
              end
              ymsc_pkg::PH_EOT_NAK: begin
                if (item_i.rx_byte == ymsc_pkg::CH_NAK) begin
                  res.action     = ymsc_pkg::ACT_EOT;
                  ns.phase       = ymsc_pkg::PH_EOT_ACK;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end else if (item_i.rx_byte == ymsc_pkg::CH_ACK) begin
                  ns.phase       = ymsc_pkg::PH_FINAL_C;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end
              end
              ymsc_pkg::PH_EOT_ACK: begin
                if (item_i.rx_byte == ymsc_pkg::CH_ACK) begin
                  ns.phase       = ymsc_pkg::PH_FINAL_C;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end else if (item_i.rx_byte == ymsc_pkg::CH_NAK) begin
                  res.action   = ymsc_pkg::ACT_RESEND;
                  ns.wait_time = 17'd0;
                end
              end
              ymsc_pkg::PH_FINAL_C: begin
                if (item_i.rx_byte == ymsc_pkg::CH_C) begin
                  res.action     = ymsc_pkg::ACT_EMPTY;
                  ns.phase       = ymsc_pkg::PH_FINAL_ACK;
                  ns.retry_count = 5'd0;
                  ns.wait_time   = 17'd0;
                end
              end
              ymsc_pkg::PH_FINAL_ACK: begin
                if (item_i.rx_byte == ymsc_pkg::CH_ACK) begin
                  ns.run_status = ymsc_pkg::ST_DONE;
                  ns.wait_time  = 17'd0;
                end else if (item_i.rx_byte == ymsc_pkg::CH_NAK) begin
                  res.action   = ymsc_pkg::ACT_RESEND;
                  ns.wait_time = 17'd0;
                end
              end
            endcase
          end
        end
        ymsc_pkg::CMD_TICK: begin
          // Accumulate time; on timeout count a retry, fail once retries run out, else resend if waiting on a frame
          ns.wait_time = tick_sum;
          if (tick_sum >= {1'b0, cfg_i.timeout_ms}) begin
            ns.wait_time   = 17'd0;
            ns.retry_count = retry_inc;
            if (retry_inc > {1'b0, cfg_i.max_retries}) begin
              ns.run_status = ymsc_pkg::ST_ERR;
              ns.fail_cause = ymsc_pkg::CAUSE_TIMEOUT;
            end else if (state_i.phase == ymsc_pkg::PH_HEADER_ACK ||
                         state_i.phase == ymsc_pkg::PH_DATA_ACK ||
                         state_i.phase == ymsc_pkg::PH_EOT_NAK ||
                         state_i.phase == ymsc_pkg::PH_EOT_ACK ||
                         state_i.phase == ymsc_pkg::PH_FINAL_ACK) begin
              res.action = ymsc_pkg::ACT_RESEND;
            end
          end
        end
        ymsc_pkg::CMD_CANCEL: begin
          res.action    = ymsc_pkg::ACT_CAN2;
          ns.run_status = ymsc_pkg::ST_ERR;
          ns.fail_cause = ymsc_pkg::CAUSE_LOCAL_CANCEL;
        end
        ymsc_pkg::CMD_RESTART: begin
          ns = ymsc_pkg::STATE_RESET;
        end
      endcase
    end else begin
      // Finished or failed: hold the state until a restart
      ns = state_i;
    end

    // Size the data block: bytes left, clipped to one block, zero past the end
    remain  = (blk_offset < cfg_i.total_bytes) ? cfg_i.total_bytes - blk_offset : 32'd0;
    blk_len = (remain > BlockMax) ? BlockMax : remain;
    if (send_blk) begin
      ns.block_length  = blk_len[10:0];
      res.action       = ymsc_pkg::ACT_DATA;
      res.block_number = ns.block_counter;
      res.read_offset  = blk_offset;
      res.read_length  = blk_len[10:0];
      ns.phase         = ymsc_pkg::PH_DATA_ACK;
      ns.retry_count   = 5'd0;
      ns.wait_time     = 17'd0;
    end

    // Report the state after the event
    res.progress_offset = ns.file_offset;
    res.status          = ns.run_status;
    res.error_cause     = ns.fail_cause;

    state_o  = ns;
    result_o = res;
  end

endmodule

FILE: hdl/ymodem_sender_controller_core.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: command; tdata: rx_byte, delta_ms
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: action; tdata: block..error_cause
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// One word per cycle unless both registers are full and the output is held.
// The rate is set by the input register feeding the combinational protocol step.
// Reset clears the protocol state, the registers return to their defaults.
// A stalled output holds its result; the input register still takes one more word.
module ymodem_sender_controller_core #(
  parameter int unsigned DATA_BLOCK_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // rx_byte[7:0], delta_ms[23:8]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // block_number[7:0], read_offset[39:8], read_length[50:40], progress_valid[51],
  // progress_offset[83:52], status[85:84], error_cause[87:86]
  output logic [87:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // action[2:0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  ymsc_pkg::cfg_t    cfg;
  ymsc_pkg::item_t   item_q;
  ymsc_pkg::state_t  state_q, state_d;
  ymsc_pkg::result_t result_q, result_d;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_take;

  ymsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ymsc_step #(
    .DATA_BLOCK_BYTES (DATA_BLOCK_BYTES)
  ) u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Move a word from the input register into the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command  <= ymsc_pkg::cmd_e'(s_axis_tuser);
      item_q.rx_byte  <= s_axis_tdata[7:0];
      item_q.delta_ms <= s_axis_tdata[23:8];
    end
  end

  // Protocol state, updated once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ymsc_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.action;
  assign m_axis_tdata  = {result_q.error_cause, result_q.status, result_q.progress_offset,
                          result_q.progress_valid, result_q.read_length,
                          result_q.read_offset, result_q.block_number};

  // Stalls only when both registers are full and the output is held
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // A restart returns the protocol to its start
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.command == ymsc_pkg::CMD_RESTART) |=>
      (state_q.phase == ymsc_pkg::PH_WAIT_C && state_q.file_offset == 32'd0 &&
       state_q.run_status == ymsc_pkg::ST_RUN && m_axis_tuser == ymsc_pkg::ACT_NONE))
    else $error("restart did not clear the state");

  // A finished or failed transfer ignores everything but a restart
  a_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.command != ymsc_pkg::CMD_RESTART &&
     state_q.run_status != ymsc_pkg::ST_RUN) |=>
      (m_axis_tuser == ymsc_pkg::ACT_NONE && $stable(state_q)))
    else $error("halted transfer produced an action");

  // Block fields are only nonzero on a data block
  a_block_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ymsc_pkg::ACT_DATA) |->
      (m_axis_tdata[50:0] == 51'd0))
    else $error("block fields set without a data block");

  // The stored block length never exceeds one block
  a_block_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.block_length) <= 32'(DATA_BLOCK_BYTES))
    else $error("block length above block size");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned BLOCK_BYTES = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Tracks the sender protocol and holds the words it expects back
  class frame_action_board;
    logic [31:0] size;
    logic [15:0] tmo;
    logic [3:0]  max_retry;

    ymsc_pkg::phase_e  phase;
    ymsc_pkg::status_e run_st;
    ymsc_pkg::cause_e  cause;
    logic [1:0]  can_cnt;
    logic [4:0]  retries;
    logic [16:0] wait_ms;
    logic [31:0] offset;
    logic [7:0]  blk;
    logic [10:0] blk_len;

    ymsc_pkg::result_t pending_actions[$];
    int unsigned mismatches;

    function new();
      size = ymsc_pkg::TOTAL_BYTES_RESET;
      tmo = ymsc_pkg::TIMEOUT_MS_RESET;
      max_retry = ymsc_pkg::MAX_RETRIES_RESET;
      mismatches = 0;
      clear_transfer();
    endfunction

    function void clear_transfer();
      phase = ymsc_pkg::PH_WAIT_C;
      run_st = ymsc_pkg::ST_RUN;
      cause = ymsc_pkg::CAUSE_NONE;
      can_cnt = 2'd0;
      retries = 5'd0;
      wait_ms = 17'd0;
      offset = 32'd0;
      blk = 8'd1;
      blk_len = 11'd0;
    endfunction

    function void write_reg(ymsc_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        ymsc_pkg::REG_TOTAL_BYTES: size = v;
        ymsc_pkg::REG_TIMEOUT_MS:  tmo = v[15:0];
        ymsc_pkg::REG_MAX_RETRIES: max_retry = v[3:0];
        default: ;
      endcase
    endfunction

    function void enter(ymsc_pkg::phase_e ph);
      phase = ph;
      retries = 5'd0;
      wait_ms = 17'd0;
    endfunction

    function void emit(inout ymsc_pkg::result_t r, input ymsc_pkg::action_e act);
      r.action = act;
      wait_ms = 17'd0;
    endfunction

    // Size the next block from what is left of the file
    function void send_block(inout ymsc_pkg::result_t r);
      logic [31:0] remain;
      remain = (offset < size) ? size - offset : 32'd0;
      blk_len = (remain > BLOCK_BYTES) ? 11'(BLOCK_BYTES) : remain[10:0];
      emit(r, ymsc_pkg::ACT_DATA);
      r.block_number = blk;
      r.read_offset = offset;
      r.read_length = blk_len;
      enter(ymsc_pkg::PH_DATA_ACK);
    endfunction

    function void on_rx(logic [7:0] ch, inout ymsc_pkg::result_t r);
      if (ch == ymsc_pkg::CH_CAN) begin
        if (can_cnt < 2'd3) can_cnt++;
        if (can_cnt >= 2'd2) begin
          run_st = ymsc_pkg::ST_ERR;
          cause = ymsc_pkg::CAUSE_RX_CANCEL;
        end
        return;
      end
      can_cnt = 2'd0;
      case (phase)
        ymsc_pkg::PH_WAIT_C: if (ch == ymsc_pkg::CH_C) begin
          emit(r, ymsc_pkg::ACT_HDR);
          enter(ymsc_pkg::PH_HEADER_ACK);
        end
        ymsc_pkg::PH_HEADER_ACK: begin
          if (ch == ymsc_pkg::CH_ACK) enter(ymsc_pkg::PH_DATA_C);
          else if (ch == ymsc_pkg::CH_NAK) emit(r, ymsc_pkg::ACT_RESEND);
        end
        ymsc_pkg::PH_DATA_C: if (ch == ymsc_pkg::CH_C) begin
          if (size == 32'd0) begin
            emit(r, ymsc_pkg::ACT_EOT);
            enter(ymsc_pkg::PH_EOT_NAK);
          end else begin
            send_block(r);
          end
        end
        ymsc_pkg::PH_DATA_ACK: begin
          if (ch == ymsc_pkg::CH_ACK) begin
            offset = offset + {21'd0, blk_len};
            r.progress_valid = 1'b1;
            if (offset >= size) begin
              emit(r, ymsc_pkg::ACT_EOT);
              enter(ymsc_pkg::PH_EOT_NAK);
            end else begin
              blk = blk + 8'd1;
              send_block(r);
            end
          end else if (ch == ymsc_pkg::CH_NAK) begin
            emit(r, ymsc_pkg::ACT_RESEND);
          end
        end
        ymsc_pkg::PH_EOT_NAK: begin
          if (ch == ymsc_pkg::CH_NAK) begin
            emit(r, ymsc_pkg::ACT_EOT);
            enter(ymsc_pkg::PH_EOT_ACK);
          end else if (ch == ymsc_pkg::CH_ACK) begin
            enter(ymsc_pkg::PH_FINAL_C);
          end
        end
        ymsc_pkg::PH_EOT_ACK: begin
          if (ch == ymsc_pkg::CH_ACK) enter(ymsc_pkg::PH_FINAL_C);
          else if (ch == ymsc_pkg::CH_NAK) emit(r, ymsc_pkg::ACT_RESEND);
        end
        ymsc_pkg::PH_FINAL_C: if (ch == ymsc_pkg::CH_C) begin
          emit(r, ymsc_pkg::ACT_EMPTY);
          enter(ymsc_pkg::PH_FINAL_ACK);
        end
        default: begin
          if (ch == ymsc_pkg::CH_ACK) begin
            run_st = ymsc_pkg::ST_DONE;
            wait_ms = 17'd0;
          end else if (ch == ymsc_pkg::CH_NAK) begin
            emit(r, ymsc_pkg::ACT_RESEND);
          end
        end
      endcase
    endfunction

    // Accumulate time; each expiry costs one retry
    function void on_tick(logic [15:0] ms, inout ymsc_pkg::result_t r);
      wait_ms = wait_ms + {1'b0, ms};
      if (wait_ms < {1'b0, tmo}) return;
      wait_ms = 17'd0;
      if (retries < 5'd31) retries++;
      if (retries > {1'b0, max_retry}) begin
        run_st = ymsc_pkg::ST_ERR;
        cause = ymsc_pkg::CAUSE_TIMEOUT;
        return;
      end
      if (phase == ymsc_pkg::PH_HEADER_ACK || phase == ymsc_pkg::PH_DATA_ACK ||
          phase == ymsc_pkg::PH_EOT_NAK || phase == ymsc_pkg::PH_EOT_ACK ||
          phase == ymsc_pkg::PH_FINAL_ACK)
        emit(r, ymsc_pkg::ACT_RESEND);
    endfunction

    function void note_word(ymsc_pkg::item_t w);
      ymsc_pkg::result_t r;
      r = '0;
      r.action = ymsc_pkg::ACT_NONE;
      if (w.command == ymsc_pkg::CMD_RESTART) begin
        clear_transfer();
      end else if (run_st == ymsc_pkg::ST_RUN) begin
        case (w.command)
          ymsc_pkg::CMD_BYTE: on_rx(w.rx_byte, r);
          ymsc_pkg::CMD_TICK: on_tick(w.delta_ms, r);
          default: begin
            r.action = ymsc_pkg::ACT_CAN2;
            run_st = ymsc_pkg::ST_ERR;
            cause = ymsc_pkg::CAUSE_LOCAL_CANCEL;
          end
        endcase
      end
      r.progress_offset = offset;
      r.status = run_st;
      r.error_cause = cause;
      pending_actions.push_back(r);
    endfunction

    function void check_result(ymsc_pkg::result_t got);
      ymsc_pkg::result_t exp;
      bit bad;
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected output word: action=%0d", $realtime, got.action);
        return;
      end
      exp = pending_actions.pop_front();
      bad = (got.action !== exp.action) || (got.block_number !== exp.block_number) ||
            (got.read_offset !== exp.read_offset) || (got.read_length !== exp.read_length) ||
            (got.progress_valid !== exp.progress_valid) ||
            (got.progress_offset !== exp.progress_offset) ||
            (got.status !== exp.status) || (got.error_cause !== exp.error_cause);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] exp act=%0d blk=%0d ro=%h rl=%0d pv=%0b po=%h st=%0d ec=%0d",
                   $realtime, exp.action, exp.block_number, exp.read_offset, exp.read_length,
                   exp.progress_valid, exp.progress_offset, exp.status, exp.error_cause);
          $display("      got act=%0d blk=%0d ro=%h rl=%0d pv=%0b po=%h st=%0d ec=%0d",
                   got.action, got.block_number, got.read_offset, got.read_length,
                   got.progress_valid, got.progress_offset, got.status, got.error_cause);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  frame_action_board sb;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned words_sent;
  int unsigned cycle_count = 0;

  ymodem_sender_controller_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the output side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Check output words and guard the run length
  always @(posedge clk_i) begin
    ymsc_pkg::result_t got;
    cycle_count++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action = ymsc_pkg::action_e'(m_axis_tuser);
      got.block_number = m_axis_tdata[7:0];
      got.read_offset = m_axis_tdata[39:8];
      got.read_length = m_axis_tdata[50:40];
      got.progress_valid = m_axis_tdata[51];
      got.progress_offset = m_axis_tdata[83:52];
      got.status = ymsc_pkg::status_e'(m_axis_tdata[85:84]);
      got.error_cause = ymsc_pkg::cause_e'(m_axis_tdata[87:86]);
      sb.check_result(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic ymsc_pkg::item_t mk(ymsc_pkg::cmd_e c, logic [7:0] b, logic [15:0] ms);
    ymsc_pkg::item_t w;
    w.command = c;
    w.rx_byte = b;
    w.delta_ms = ms;
    return w;
  endfunction

  // Pick the next event: mostly what moves the transfer forward, plus noise
  function automatic ymsc_pkg::item_t next_event(bit clean);
    ymsc_pkg::item_t w;
    int unsigned roll;
    logic [7:0] good;
    w.command = ymsc_pkg::CMD_BYTE;
    w.rx_byte = 8'($urandom_range(255));
    w.delta_ms = 16'($urandom_range(65535));
    roll = $urandom_range(99);
    case (sb.phase)
      ymsc_pkg::PH_WAIT_C, ymsc_pkg::PH_DATA_C, ymsc_pkg::PH_FINAL_C: good = ymsc_pkg::CH_C;
      ymsc_pkg::PH_EOT_NAK: good = $urandom_range(1) ? ymsc_pkg::CH_NAK : ymsc_pkg::CH_ACK;
      default: good = ymsc_pkg::CH_ACK;
    endcase
    if (sb.run_st != ymsc_pkg::ST_RUN) begin
      if (clean || roll < 75) w.command = ymsc_pkg::CMD_RESTART;
      else w.command = ymsc_pkg::cmd_e'($urandom_range(2));
    end else if (clean) begin
      if (roll < 92) begin
        w.rx_byte = good;
      end else if (roll < 96) begin
        w.rx_byte = ymsc_pkg::CH_NAK;
      end else begin
        w.command = ymsc_pkg::CMD_TICK;
        w.delta_ms = 16'($urandom_range(200));
      end
    end else if (roll < 55) begin
      w.rx_byte = good;
    end else if (roll < 63) begin
      w.rx_byte = ymsc_pkg::CH_NAK;
    end else if (roll < 77) begin
      w.command = ymsc_pkg::CMD_TICK;
      case ($urandom_range(3))
        0: w.delta_ms = sb.tmo;
        1: w.delta_ms = 16'($urandom_range(sb.tmo));
        2: w.delta_ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: ;
      endcase
    end else if (roll < 82) begin
      w.rx_byte = ymsc_pkg::CH_CAN;
    end else if (roll < 91) begin
      // keep the random byte
    end else if (roll < 94) begin
      w.command = ymsc_pkg::CMD_CANCEL;
    end else if (roll < 96) begin
      w.command = ymsc_pkg::CMD_RESTART;
    end else begin
      case ($urandom_range(3))
        0: w.rx_byte = ymsc_pkg::CH_C;
        1: w.rx_byte = ymsc_pkg::CH_ACK;
        2: w.rx_byte = ymsc_pkg::CH_NAK;
        default: w.rx_byte = ymsc_pkg::CH_CAN;
      endcase
    end
    return w;
  endfunction

  // Present one word and hold it until taken
  task automatic send_word(ymsc_pkg::item_t w);
    if (words_sent < 380) begin
      send_idle = 14;
      recv_idle = 55;
    end else if (words_sent < 760) begin
      send_idle = 55;
      recv_idle = 14;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w.delta_ms, w.rx_byte};
    s_axis_tuser <= w.command;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  // Drain all pending words, then write the registers while idle
  task automatic run_phase(logic [31:0] fs, logic [15:0] tmo, logic [3:0] mr,
                           int unsigned n, bit clean);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ymsc_pkg::REG_TOTAL_BYTES;
    cfg_data_i <= fs;
    @(posedge clk_i);
    cfg_idx_i <= ymsc_pkg::REG_TIMEOUT_MS;
    cfg_data_i <= {16'd0, tmo};
    @(posedge clk_i);
    cfg_idx_i <= ymsc_pkg::REG_MAX_RETRIES;
    cfg_data_i <= {28'd0, mr};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(ymsc_pkg::REG_TOTAL_BYTES, fs);
    sb.write_reg(ymsc_pkg::REG_TIMEOUT_MS, {16'd0, tmo});
    sb.write_reg(ymsc_pkg::REG_MAX_RETRIES, {28'd0, mr});
    repeat (n) send_word(next_event(clean));
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    words_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ymsc_pkg::CMD_BYTE;
    cfg_we_i = 1'b0;
    cfg_idx_i = ymsc_pkg::REG_TOTAL_BYTES;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk an empty-file transfer on the reset defaults, then the failure paths
    send_word(mk(ymsc_pkg::CMD_TICK, 8'h00, 16'd0));
    send_word(mk(ymsc_pkg::CMD_TICK, 8'hFF, 16'hFFFF));
    send_word(mk(ymsc_pkg::CMD_BYTE, 8'hFF, 16'h0000));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_C, 16'hFFFF));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_NAK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_TICK, 8'h00, 16'd1000));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_CAN, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_ACK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_C, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_NAK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_NAK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_ACK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_C, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_NAK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_ACK, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_C, 16'd0));
    send_word(mk(ymsc_pkg::CMD_CANCEL, 8'h00, 16'd0));
    send_word(mk(ymsc_pkg::CMD_RESTART, 8'hFF, 16'hFFFF));
    send_word(mk(ymsc_pkg::CMD_CANCEL, 8'h00, 16'd0));
    send_word(mk(ymsc_pkg::CMD_RESTART, 8'h00, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_CAN, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_CAN, 16'd0));
    send_word(mk(ymsc_pkg::CMD_BYTE, ymsc_pkg::CH_CAN, 16'd0));
    send_word(mk(ymsc_pkg::CMD_RESTART, 8'h00, 16'd0));

    // Random transfers over a range of register settings
    run_phase(32'd3000, 16'd1000, 4'd10, 120, 1'b0);
    // long clean transfer so the block number wraps
    run_phase(32'd307207, 16'hFFFF, 4'd15, 400, 1'b1);
    run_phase(32'd1, 16'd1, 4'd0, 80, 1'b0);
    run_phase(32'd0, 16'd0, 4'd15, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'd500, 4'd3, 80, 1'b1);
    // shrink the file under a running transfer
    run_phase(32'd100, 16'd2000, 4'd5, 80, 1'b0);
    run_phase(32'd1024, 16'hFFFF, 4'd15, 80, 1'b1);
    for (int k = 0; k < 3; k++)
      run_phase(32'($urandom_range(6000, 1)), 16'($urandom_range(65535, 1)),
                4'($urandom_range(15)), 80, 1'b0);

    // Let the last words come back
    s_axis_tvalid <= 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: ymodem_sender_controller_core.f
hdl/ymsc_pkg.sv
hdl/ymsc_cfg_regs.sv
hdl/ymsc_step.sv
hdl/ymodem_sender_controller_core.sv
dv/tb.sv
